>>> design/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the caliper frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // Item action codes.
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_ZERO = 2'd2;

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int GAP_W    = 8;
  localparam int VALUE_W  = 21;
  localparam int DISP_W   = 22;
  localparam int AGE_OUT_W = 32;

  // Age counter width default.
  localparam int AGE_BITS_DEFAULT = 32;

  // Frame byte decoding.
  localparam logic [7:0] NIBBLE_MASK = 8'h0f;
  localparam logic [7:0] ERROR_MASK  = 8'b1110_0000;
  localparam logic [7:0] SIGN_MASK   = 8'h10;

  // Reset value of the quiet gap register.
  localparam logic [GAP_W-1:0] GAP_RESET = 8'd10;

  // Byte positions within a frame.
  localparam logic [1:0] POS_LOW = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_TOP = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic                clk_level;
    logic                raw_select;
  } cfd_item_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] displacement;
    logic [AGE_OUT_W-1:0]     age_ticks;
    logic                     frame_done;
    logic                     frame_error;
    logic                     resyncing;
  } cfd_result_t;

endpackage

>>> design/cfd_item_if.sv
// ----------------------------------------------------------------------------
// cfd_item_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface cfd_item_if
  import cfd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   data_byte;
  logic                clk_level;
  logic                raw_select;

  modport source (output valid, action, data_byte, clk_level, raw_select, input ready);
  modport sink   (input valid, action, data_byte, clk_level, raw_select, output ready);
endinterface

>>> design/cfd_result_if.sv
// ----------------------------------------------------------------------------
// cfd_result_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface cfd_result_if
  import cfd_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] displacement;
  logic [AGE_OUT_W-1:0]     age_ticks;
  logic                     frame_done;
  logic                     frame_error;
  logic                     resyncing;

  modport source (output valid, displacement, age_ticks, frame_done, frame_error,
                  resyncing, input ready);
  modport sink   (input valid, displacement, age_ticks, frame_done, frame_error,
                  resyncing, output ready);
endinterface

>>> design/cfd_cfg_if.sv
// ----------------------------------------------------------------------------
// cfd_cfg_if
// Configuration write channel for the quiet gap register.
// ----------------------------------------------------------------------------
interface cfd_cfg_if
  import cfd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [GAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/caliper_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// caliper_frame_decoder_top
// Caliper serial frame decoder with one registered result per item.
// ----------------------------------------------------------------------------
// Each accepted item (a received byte, a timer tick carrying the sampled
// serial clock level, or a set-zero command) produces exactly one result,
// registered in the next cycle. Three bytes, low byte first, make a
// frame: the low nibble of the third byte holds the top four bits of a
// 20-bit magnitude, bit 4 negates it, and any of bits 5 to 7 marks a bad
// frame, which is stored un-negated and puts the decoder into resync. In
// resync, bytes are dropped until the clock level has stayed unchanged for
// quiet_gap ticks (reset value 10). Ticks also advance a saturating
// age counter that clears on every completed frame. The displacement is the
// current value, or the current value minus the captured zero offset when
// raw_select is low. Throughput is one item per cycle: the whole state
// update is a single pass of logic between the item handshake and the
// result register, so an item is taken in every cycle in which the result
// register is empty or its content is being transferred out. The
// configuration channel is always ready and should only be written while
// no item is in flight.
// ----------------------------------------------------------------------------
module caliper_frame_decoder_top
  import cfd_pkg::*;
#(
  parameter int AGE_BITS = AGE_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  cfd_item_if.sink      item,
  cfd_result_if.source  result,
  cfd_cfg_if.sink       cfg
);

  // Quiet gap register, written by the configuration channel.
  logic [GAP_W-1:0] quiet_gap;

  // Result register and its valid flag.
  logic        out_valid;
  cfd_result_t out_data;

  cfd_item_t   item_fields;
  cfd_result_t core_result;
  logic        accept;

  // The configuration register takes each write directly, so the channel
  // never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_gap <= GAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      quiet_gap <= cfg.data;
    end
  end

  // A new item enters whenever the result register is free this cycle,
  // either empty or handing its content to the sink.
  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;

  always_comb begin
    item_fields.action     = item.action;
    item_fields.data_byte  = item.data_byte;
    item_fields.clk_level  = item.clk_level;
    item_fields.raw_select = item.raw_select;
  end

  cfd_frame_core #(
    .AGE_BITS (AGE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item_fields),
    .quiet_gap (quiet_gap),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload register needs no reset; it is only read while out_valid is set.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= core_result;
    end
  end

  assign result.valid        = out_valid;
  assign result.displacement = out_data.displacement;
  assign result.age_ticks    = out_data.age_ticks;
  assign result.frame_done   = out_data.frame_done;
  assign result.frame_error  = out_data.frame_error;
  assign result.resyncing    = out_data.resyncing;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !accept)
    else $error("item accepted while a stalled result would be overwritten");

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item did not produce a result");

  a_cfg_takes_data: assert property (@(posedge clk) disable iff (rst)
    cfg.valid |=> quiet_gap == $past(cfg.data))
    else $error("configuration write was not captured");
`endif

endmodule

>>> design/cfd_frame_core.sv
// ----------------------------------------------------------------------------
// cfd_frame_core
// Decoder state and its one-pass update; produces the result of each item.
// ----------------------------------------------------------------------------
module cfd_frame_core
  import cfd_pkg::*;
#(
  parameter int AGE_BITS = AGE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  cfd_item_t        item,
  input  logic [GAP_W-1:0] quiet_gap,
  output cfd_result_t      result
);

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic [GAP_W-1:0]    QUIET_MAX = {GAP_W{1'b1}};

  logic [1:0]          byte_position, byte_position_next;
  logic [BYTE_W-1:0]   low_byte, low_byte_next;
  logic [BYTE_W-1:0]   mid_byte, mid_byte_next;
  logic [VALUE_W-1:0]  current_value, current_value_next;
  logic [VALUE_W-1:0]  zero_offset, zero_offset_next;
  logic [AGE_BITS-1:0] age_count, age_count_next;
  logic                in_resync, in_resync_next;
  logic                prev_clk, prev_clk_next;
  logic [GAP_W-1:0]    quiet_count, quiet_count_next;

  logic [VALUE_W-1:0]  magnitude;
  logic                done;
  logic                err;
  logic [DISP_W-1:0]   disp_raw;
  logic [DISP_W-1:0]   disp_offset;

  assign magnitude = {1'b0, item.data_byte[3:0] & NIBBLE_MASK[3:0], mid_byte, low_byte};

  always_comb begin
    byte_position_next = byte_position;
    low_byte_next      = low_byte;
    mid_byte_next      = mid_byte;
    current_value_next = current_value;
    zero_offset_next   = zero_offset;
    age_count_next     = age_count;
    in_resync_next     = in_resync;
    prev_clk_next      = prev_clk;
    quiet_count_next   = quiet_count;
    done               = 1'b0;
    err                = 1'b0;
    case (item.action)
      ACT_BYTE: begin
        if (!in_resync) begin
          case (byte_position)
            POS_LOW: begin
              low_byte_next      = item.data_byte;
              byte_position_next = POS_MID;
            end
            POS_MID: begin
              mid_byte_next      = item.data_byte;
              byte_position_next = POS_TOP;
            end
            default: begin
              // Third byte (or a stray position) closes the frame.
              done = 1'b1;
              if ((item.data_byte & ERROR_MASK) != '0) begin
                err                = 1'b1;
                current_value_next = magnitude;
                in_resync_next     = 1'b1;
                prev_clk_next      = 1'b0;
                quiet_count_next   = '0;
              end else if ((item.data_byte & SIGN_MASK) != '0) begin
                current_value_next = VALUE_W'(-magnitude);
              end else begin
                current_value_next = magnitude;
              end
              byte_position_next = POS_LOW;
              age_count_next     = '0;
            end
          endcase
        end
      end
      ACT_TICK: begin
        if (age_count != AGE_MAX) begin
          age_count_next = age_count + 1'b1;
        end
        if (in_resync) begin
          if (item.clk_level != prev_clk) begin
            prev_clk_next    = item.clk_level;
            quiet_count_next = '0;
          end else if (quiet_count != QUIET_MAX) begin
            quiet_count_next = quiet_count + 1'b1;
          end
          if (quiet_count_next >= quiet_gap) begin
            in_resync_next = 1'b0;
          end
        end
      end
      ACT_ZERO: begin
        zero_offset_next = current_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_LOW;
      low_byte      <= '0;
      mid_byte      <= '0;
      current_value <= '0;
      zero_offset   <= '0;
      age_count     <= '0;
      in_resync     <= 1'b0;
      prev_clk      <= 1'b0;
      quiet_count   <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      low_byte      <= low_byte_next;
      mid_byte      <= mid_byte_next;
      current_value <= current_value_next;
      zero_offset   <= zero_offset_next;
      age_count     <= age_count_next;
      in_resync     <= in_resync_next;
      prev_clk      <= prev_clk_next;
      quiet_count   <= quiet_count_next;
    end
  end

  assign disp_raw    = {current_value_next[VALUE_W-1], current_value_next};
  assign disp_offset = disp_raw - {zero_offset_next[VALUE_W-1], zero_offset_next};

  assign result.displacement = signed'(item.raw_select ? disp_raw : disp_offset);
  assign result.frame_done   = done;
  assign result.frame_error  = err;
  assign result.resyncing    = in_resync_next;

  // The reported age saturates at the width of the result field.
  if (AGE_BITS > AGE_OUT_W) begin : g_age_sat
    assign result.age_ticks = (|age_count_next[AGE_BITS-1:AGE_OUT_W]) ?
                              {AGE_OUT_W{1'b1}} : age_count_next[AGE_OUT_W-1:0];
  end else begin : g_age_ext
    assign result.age_ticks = AGE_OUT_W'(age_count_next);
  end

`ifndef NO_ASSERTIONS
  a_error_is_done: assert property (@(posedge clk) disable iff (rst)
    accept && result.frame_error |-> result.frame_done)
    else $error("frame error reported without a completed frame");

  a_done_clears_age: assert property (@(posedge clk) disable iff (rst)
    accept && result.frame_done |=> age_count == '0 && byte_position == POS_LOW)
    else $error("completed frame did not clear age and byte position");

  a_error_enters_resync: assert property (@(posedge clk) disable iff (rst)
    accept && result.frame_error |=> in_resync && quiet_count == '0 && !prev_clk)
    else $error("bad frame did not enter resync cleanly");

  a_resync_ignores_bytes: assert property (@(posedge clk) disable iff (rst)
    accept && in_resync && item.action == ACT_BYTE
    |=> byte_position == $past(byte_position) && in_resync)
    else $error("byte changed framing state during resync");
`endif

endmodule
